### src/ledd_pkg.sv
// Shared types and constants for the addressable LED duty encoder.
package ledd_pkg;

	localparam int BYTE_W     = 8;
	localparam int PIXEL_BITS = 24;
	localparam int BRIGHT_W   = 12;
	localparam int DUTY_W     = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DUTY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_DUTY   = 2'd2;

	localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RST = 12'd4095;

	typedef struct packed {
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] blue;
		logic              last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              is_data;
		logic              run_end;
	} slot_t;

	// One scaled pixel handed from the lanes to the serializer.
	typedef struct packed {
		logic [PIXEL_BITS-1:0] bits;
		logic                  last;
		logic                  lead;
	} job_t;

endpackage

### src/ledd_lane.sv
// One color lane: scales a byte by brightness and registers the result.
module ledd_lane #(
	parameter int SCALE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ledd_pkg::BYTE_W-1:0]   color,
	input  logic [ledd_pkg::BRIGHT_W-1:0] brightness,
	output logic [ledd_pkg::BYTE_W-1:0]   scaled
);
	import ledd_pkg::*;

	localparam int FACT_W = BRIGHT_W + 1;
	localparam int PROD_W = BYTE_W + FACT_W;

	logic [FACT_W-1:0] factor;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] shifted;
	logic [BYTE_W-1:0] sat;
	logic [BYTE_W-1:0] scaled_s1;

	assign factor  = {1'b0, brightness} + FACT_W'(1);
	assign prod    = PROD_W'(color) * PROD_W'(factor);
	assign shifted = prod >> SCALE_BITS;
	// saturate anything above one byte
	assign sat     = (|shifted[PROD_W-1:BYTE_W]) ? {BYTE_W{1'b1}} : shifted[BYTE_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			scaled_s1 <= sat;
		end
	end

	assign scaled = scaled_s1;

endmodule

### src/ledd_serializer.sv
// Merges the lane results into a stream of duty slots with padding and reset code.
module ledd_serializer #(
	parameter int PAD_SLOTS   = 2,
	parameter int RESET_SLOTS = 30
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	output logic                        job_ready,
	input  ledd_pkg::job_t              job,
	input  logic [ledd_pkg::DUTY_W-1:0] high_duty,
	input  logic [ledd_pkg::DUTY_W-1:0] low_duty,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ledd_pkg::slot_t             out_data
);
	import ledd_pkg::*;

	localparam int TAIL_SLOTS = PAD_SLOTS + RESET_SLOTS;
	localparam int MAX_CNT    = (TAIL_SLOTS > PIXEL_BITS) ? TAIL_SLOTS - 1 : PIXEL_BITS - 1;
	localparam int CNT_W      = $clog2(MAX_CNT + 1);
	localparam logic [CNT_W-1:0] DATA_LAST = CNT_W'(PIXEL_BITS - 1);
	localparam logic [CNT_W-1:0] TAIL_LAST = CNT_W'(TAIL_SLOTS - 1);
	localparam logic [CNT_W-1:0] LEAD_LAST = CNT_W'((PAD_SLOTS > 0) ? PAD_SLOTS - 1 : 0);

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_DATA,
		PH_TAIL
	} phase_t;

	logic                  busy_q;
	phase_t                phase_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PIXEL_BITS-1:0] bits_q;
	logic                  last_q;
	logic                  out_valid_q;
	slot_t                 out_q;

	logic   advance;
	logic   finish;
	logic   take;
	slot_t  slot;

	assign advance = busy_q && (!out_valid_q || out_ready);

	// current slot and whether it closes the run
	always_comb begin
		slot   = '0;
		finish = 1'b0;
		unique case (phase_q)
			PH_LEAD: begin
				slot = '0;
			end
			PH_DATA: begin
				slot.duty    = bits_q[PIXEL_BITS-1] ? high_duty : low_duty;
				slot.is_data = 1'b1;
				if (cnt_q == '0 && !last_q) begin
					slot.run_end = 1'b1;
					finish       = 1'b1;
				end
			end
			PH_TAIL: begin
				if (cnt_q == '0) begin
					slot.run_end = 1'b1;
					finish       = 1'b1;
				end
			end
			default: begin
				slot = '0;
			end
		endcase
	end

	assign job_ready = !busy_q || (advance && finish);
	assign take      = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= PH_DATA;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (take) begin
				busy_q <= 1'b1;
				if (job.lead && PAD_SLOTS > 0) begin
					phase_q <= PH_LEAD;
					cnt_q   <= LEAD_LAST;
				end else begin
					phase_q <= PH_DATA;
					cnt_q   <= DATA_LAST;
				end
			end else if (advance) begin
				if (finish) begin
					busy_q <= 1'b0;
				end else if (cnt_q != '0) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end else if (phase_q == PH_LEAD) begin
					phase_q <= PH_DATA;
					cnt_q   <= DATA_LAST;
				end else begin
					phase_q <= PH_TAIL;
					cnt_q   <= TAIL_LAST;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= slot;
		end
		if (take) begin
			bits_q <= job.bits;
			last_q <= job.last;
		end else if (advance && phase_q == PH_DATA) begin
			bits_q <= {bits_q[PIXEL_BITS-2:0], 1'b0};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_data_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && phase_q == PH_DATA) |-> (cnt_q <= DATA_LAST))
		else $error("data slot counter out of range");

	a_last_no_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PH_DATA && cnt_q == '0 && last_q) |=> !out_q.run_end)
		else $error("run ended before trailing padding of last pixel");

	a_adv_valid: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("emitted slot not presented");

	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		(take && busy_q) |-> (advance && finish))
		else $error("new pixel loaded over a running one");

endmodule

### src/addressable_led_duty_encoder.sv
// Top level of the addressable LED duty encoder: three scaling lanes and a slot serializer.
// Each accepted pixel yields 24 duty slots (green, red, blue, MSB first), one slot per clock
// while out_ready is high; the serializer's single output port limits the sustained rate.
// The first pixel of a frame adds PAD_SLOTS leading zero slots, and a last pixel adds
// PAD_SLOTS + RESET_SLOTS trailing zero slots, each also one per clock when not stalled.
// A pixel is scaled in the cycle it is accepted and held in the lane registers, then loaded
// into the serializer; the next pixel is accepted while the current one is still being sent.
module addressable_led_duty_encoder #(
	parameter int SCALE_BITS  = 12,
	parameter int PAD_SLOTS   = 2,
	parameter int RESET_SLOTS = 30
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ledd_pkg::pixel_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ledd_pkg::slot_t                out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ledd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ledd_pkg::DUTY_W-1:0]    cfg_data
);
	import ledd_pkg::*;

	logic [BRIGHT_W-1:0] brightness_q;
	logic [DUTY_W-1:0]   high_duty_q;
	logic [DUTY_W-1:0]   low_duty_q;
	logic                in_frame_q;
	logic                valid_s1;
	logic                last_s1;
	logic                lead_s1;

	logic                in_take;
	logic                job_ready;
	logic [BYTE_W-1:0]   green_sc;
	logic [BYTE_W-1:0]   red_sc;
	logic [BYTE_W-1:0]   blue_sc;
	job_t                job;

	assign cfg_ready = 1'b1;
	assign in_ready  = !valid_s1 || job_ready;
	assign in_take   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= BRIGHTNESS_RST;
			high_duty_q  <= '0;
			low_duty_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BRIGHTNESS: brightness_q <= cfg_data[BRIGHT_W-1:0];
				CFG_HIGH_DUTY:  high_duty_q  <= cfg_data;
				CFG_LOW_DUTY:   low_duty_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// frame tracking and stage-1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			valid_s1   <= 1'b0;
		end else begin
			if (in_take) begin
				in_frame_q <= !in_data.last_pixel;
				valid_s1   <= 1'b1;
			end else if (job_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			last_s1 <= in_data.last_pixel;
			lead_s1 <= !in_frame_q;
		end
	end

	ledd_lane #(.SCALE_BITS(SCALE_BITS)) u_lane_g (
		.clk       (clk),
		.en        (in_take),
		.color     (in_data.green),
		.brightness(brightness_q),
		.scaled    (green_sc)
	);

	ledd_lane #(.SCALE_BITS(SCALE_BITS)) u_lane_r (
		.clk       (clk),
		.en        (in_take),
		.color     (in_data.red),
		.brightness(brightness_q),
		.scaled    (red_sc)
	);

	ledd_lane #(.SCALE_BITS(SCALE_BITS)) u_lane_b (
		.clk       (clk),
		.en        (in_take),
		.color     (in_data.blue),
		.brightness(brightness_q),
		.scaled    (blue_sc)
	);

	assign job.bits = {green_sc, red_sc, blue_sc};
	assign job.last = last_s1;
	assign job.lead = lead_s1;

	ledd_serializer #(
		.PAD_SLOTS  (PAD_SLOTS),
		.RESET_SLOTS(RESET_SLOTS)
	) u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(valid_s1),
		.job_ready(job_ready),
		.job      (job),
		.high_duty(high_duty_q),
		.low_duty (low_duty_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
